// File: rtl/mexp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, register indexes, state and command types for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

	localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET  = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] EXPONENT_RESET = VALUE_WIDTH'(1);

	localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(VALUE_WIDTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_CHK,
		ST_MUL,
		ST_SQ0,
		ST_SQR,
		ST_FIN
	} state_t;

	// Operation of the shared modular multiplier.
	typedef enum logic [1:0] {
		MOP_RED,
		MOP_MUL,
		MOP_SQR
	} mop_t;

	typedef struct packed {
		logic load;
		logic mstart;
		mop_t mop;
		logic mstep;
		logic eshift;
	} dp_cmd_t;

	typedef struct packed {
		logic e_zero;
		logic e_lsb;
		logic e_rest_zero;
		logic mul_last;
		logic mod_small;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/mexp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: accumulator, square register, exponent shifter and a bit-serial
// interleaved modular multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mexp_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mexp_pkg::dp_cmd_t                cmd,
	output mexp_pkg::dp_sts_t                     sts,
	input  wire logic [mexp_pkg::VALUE_WIDTH-1:0] base_value,
	input  wire logic [mexp_pkg::VALUE_WIDTH-1:0] modulus,
	input  wire logic [mexp_pkg::VALUE_WIDTH-1:0] exponent,
	output logic      [mexp_pkg::VALUE_WIDTH-1:0] result_value
);

	localparam int W = mexp_pkg::VALUE_WIDTH;

	logic [W-1:0]               acc_q;
	logic [W-1:0]               sq_q;
	logic [W-1:0]               e_q;
	logic [W-1:0]               r_q;
	logic [W-1:0]               b_q;
	logic [mexp_pkg::CNT_W-1:0] cnt_q;
	mexp_pkg::mop_t             op_q;

	logic [W-1:0] a_op;
	logic [W+1:0] t_sum;
	logic [W+1:0] m1;
	logic [W+1:0] m2;
	logic [W-1:0] r_next;

	always_comb begin
		case (op_q)
			mexp_pkg::MOP_RED: a_op = W'(1);
			mexp_pkg::MOP_MUL: a_op = acc_q;
			mexp_pkg::MOP_SQR: a_op = sq_q;
			default:           a_op = sq_q;
		endcase
	end

	// r stays below m: 2r + a is below 3m, so at most one of m or 2m comes off.
	always_comb begin
		t_sum = {1'b0, r_q, 1'b0} + {2'b00, (b_q[W-1] ? a_op : W'(0))};
		m1    = {2'b00, modulus};
		m2    = {1'b0, modulus, 1'b0};
		priority if (t_sum >= m2) begin
			r_next = W'(t_sum - m2);
		end else if (t_sum >= m1) begin
			r_next = W'(t_sum - m1);
		end else begin
			r_next = W'(t_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q  <= mexp_pkg::MOP_RED;
		end else if (cmd.load) begin
			cnt_q <= '0;
			op_q  <= mexp_pkg::MOP_RED;
		end else if (cmd.mstart) begin
			cnt_q <= '0;
			op_q  <= cmd.mop;
		end else if (cmd.mstep) begin
			cnt_q <= cnt_q + mexp_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= W'(1);
			e_q   <= exponent;
			b_q   <= base_value;
			r_q   <= '0;
		end else if (cmd.mstart) begin
			b_q <= sq_q;
			r_q <= '0;
		end else if (cmd.mstep) begin
			b_q <= {b_q[W-2:0], 1'b0};
			r_q <= r_next;
			if (cnt_q == mexp_pkg::BIT_LAST) begin
				if (op_q == mexp_pkg::MOP_MUL) begin
					acc_q <= r_next;
				end else begin
					sq_q <= r_next;
				end
			end
		end
		if (cmd.eshift) begin
			e_q <= {1'b0, e_q[W-1:1]};
		end
	end

	always_comb begin
		sts.e_zero      = (e_q == '0);
		sts.e_lsb       = e_q[0];
		sts.e_rest_zero = (e_q[W-1:1] == '0);
		sts.mul_last    = (cnt_q == mexp_pkg::BIT_LAST);
		sts.mod_small   = (modulus[W-1:1] == '0);
	end

	assign result_value = sts.mod_small ? '0 : acc_q;

endmodule
`default_nettype wire

// File: rtl/mexp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences the base reduction and the square-and-multiply loop
// over the exponent bits, least significant bit first.
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output mexp_pkg::dp_cmd_t      cmd,
	input  wire mexp_pkg::dp_sts_t sts
);

	mexp_pkg::state_t state_q;
	mexp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mexp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.mstart = 1'b0;
		cmd.mop    = mexp_pkg::MOP_MUL;
		cmd.mstep  = 1'b0;
		cmd.eshift = 1'b0;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = sts.mod_small ? mexp_pkg::ST_FIN : mexp_pkg::ST_RED;
				end
			end
			mexp_pkg::ST_RED: begin
				cmd.mstep = 1'b1;
				if (sts.mul_last) begin
					state_d = mexp_pkg::ST_CHK;
				end
			end
			mexp_pkg::ST_CHK: begin
				priority if (sts.e_zero) begin
					state_d = mexp_pkg::ST_FIN;
				end else if (sts.e_lsb) begin
					cmd.mstart = 1'b1;
					cmd.mop    = mexp_pkg::MOP_MUL;
					state_d    = mexp_pkg::ST_MUL;
				end else begin
					cmd.mstart = 1'b1;
					cmd.mop    = mexp_pkg::MOP_SQR;
					state_d    = mexp_pkg::ST_SQR;
				end
			end
			mexp_pkg::ST_MUL: begin
				cmd.mstep = 1'b1;
				if (sts.mul_last) begin
					state_d = mexp_pkg::ST_SQ0;
				end
			end
			mexp_pkg::ST_SQ0: begin
				// The square after the top exponent bit would never be used.
				if (sts.e_rest_zero) begin
					state_d = mexp_pkg::ST_FIN;
				end else begin
					cmd.mstart = 1'b1;
					cmd.mop    = mexp_pkg::MOP_SQR;
					state_d    = mexp_pkg::ST_SQR;
				end
			end
			mexp_pkg::ST_SQR: begin
				cmd.mstep = 1'b1;
				if (sts.mul_last) begin
					cmd.eshift = 1'b1;
					state_d    = mexp_pkg::ST_CHK;
				end
			end
			mexp_pkg::ST_FIN: begin
				state_d = mexp_pkg::ST_IDLE;
			end
			default: begin
				state_d = mexp_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != mexp_pkg::ST_IDLE);
	assign done = (state_q == mexp_pkg::ST_FIN);

endmodule
`default_nettype wire

// File: rtl/modular_exponentiation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises each input value to the configured exponent modulo the configured
// modulus with square-and-multiply over a bit-serial modular multiplier.
//
//   Channel   Handshake              Payload
//   input     start, busy            base_value
//   result    done (one cycle)       result_value
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A multiplication retires one multiplier bit per cycle.
// An item runs the base reduction, then for each exponent bit a multiply if the
// bit is set and a square unless it is the top set bit, then the result beat.
// A modulus below two gives a result of zero in the cycle after start.
// Reset clears the controller and loads modulus 2 and exponent 1.
// The result beat is shown for one cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module modular_exponentiation (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [mexp_pkg::VALUE_WIDTH-1:0] base_value,
	output logic                                  done,
	output logic      [mexp_pkg::VALUE_WIDTH-1:0] result_value,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mexp_pkg::VALUE_WIDTH-1:0] cfg_data
);

	logic [mexp_pkg::VALUE_WIDTH-1:0] modulus_q;
	logic [mexp_pkg::VALUE_WIDTH-1:0] exponent_q;
	mexp_pkg::dp_cmd_t                cmd;
	mexp_pkg::dp_sts_t                sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= mexp_pkg::MODULUS_RESET;
			exponent_q <= mexp_pkg::EXPONENT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mexp_pkg::REG_MODULUS) begin
				modulus_q <= cfg_data;
			end
			if (cfg_index == mexp_pkg::REG_EXPONENT) begin
				exponent_q <= cfg_data;
			end
		end
	end

	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	mexp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.base_value   (base_value),
		.modulus      (modulus_q),
		.exponent     (exponent_q),
		.result_value (result_value)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("controller did not return to idle after the result beat");

	a_small_mod: assert property (@(posedge clk) disable iff (!arst_n)
		done && sts.mod_small |-> result_value == '0)
		else $error("nonzero result for a modulus below two");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done && !sts.mod_small |-> result_value < modulus_q)
		else $error("result not reduced below the modulus");

endmodule
`default_nettype wire
